[hw/rtl/lru_page_victim_selector_unit_macros.svh]
// ----------------------------------------------------------------------------
// LRU page victim selector assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_VICTIM_SELECTOR_UNIT_MACROS_SVH
`define LRU_PAGE_VICTIM_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication
`define LPVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpvs assertion failed");

// Next-cycle implication
`define LPVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpvs assertion failed");

`endif

[hw/rtl/lpvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page victim selector package
// Field widths, stamp width and the sequencer state type.
// ----------------------------------------------------------------------------
package lpvs_pkg;

  localparam int PidW      = 5;
  localparam int PcW       = 12;
  localparam int ResW      = 32;
  localparam int CountW    = 6;
  localparam int PageW     = 5;
  localparam int StampW    = 32;
  localparam int MaxPages  = 32;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_EVAL,
    S_SEARCH,
    S_DONE
  } lpvs_state_e;

endpackage

[hw/rtl/lpvs_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page victim selector input channel
// Valid/ready channel carrying one process descriptor per beat.
// ----------------------------------------------------------------------------
interface lpvs_in_if
  import lpvs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PidW-1:0]   process_id;
  logic              is_active;
  logic [PcW-1:0]    program_counter;
  logic [ResW-1:0]   resident_pages;
  logic [CountW-1:0] page_count;
  logic              memory_full;
  logic              end_of_round;

  modport source (
    output valid, process_id, is_active, program_counter, resident_pages,
           page_count, memory_full, end_of_round,
    input  ready
  );

  modport sink (
    input  valid, process_id, is_active, program_counter, resident_pages,
           page_count, memory_full, end_of_round,
    output ready
  );
endinterface

[hw/rtl/lpvs_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page victim selector output channel
// Valid/ready channel carrying one page decision per beat.
// ----------------------------------------------------------------------------
interface lpvs_out_if
  import lpvs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PageW-1:0] want_page;
  logic             request_pagein;
  logic             request_pageout;
  logic             victim_found;
  logic [PageW-1:0] victim_page;

  modport source (
    output valid, want_page, request_pagein, request_pageout, victim_found,
           victim_page,
    input  ready
  );

  modport sink (
    input  valid, want_page, request_pagein, request_pageout, victim_found,
           victim_page,
    output ready
  );
endinterface

[hw/rtl/lru_page_victim_selector_unit.sv]
`timescale 1ns / 1ps
// Sequence: a beat is accepted in S_IDLE, then passes S_DIV, S_EVAL and S_DONE; on a page
//   miss with memory full, S_SEARCH scans pages 0 to L-1, L = min(page_count, pages, 32).
// Beats: one at a time, the scan reading the stamp memory one read per cycle; the next
//   beat is taken while a result waits in the output register; S_DONE waits while it is full.
// Reset: async active low; then a clearing pass over all PROCESS_SLOTS*PAGES_PER_PROCESS
//   entries zeroes the stamp memory before the first beat is taken. Tick resets to one.
// ----------------------------------------------------------------------------
// LRU page victim selector
// Stamps the current page of each active process with the running tick and,
// on a miss with memory full, scans the stamp memory for the oldest resident
// non-current page of that process.
// ----------------------------------------------------------------------------
`include "lru_page_victim_selector_unit_macros.svh"

module lru_page_victim_selector_unit
  import lpvs_pkg::*;
#(
  parameter int PROCESS_SLOTS     = 32,
  parameter int PAGES_PER_PROCESS = 32,
  parameter int PAGE_BYTES        = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpvs_in_if.sink    in_i,
  lpvs_out_if.source out_o
);

  localparam int Depth   = PROCESS_SLOTS * PAGES_PER_PROCESS;
  localparam int AddrW   = $clog2(Depth);
  localparam int PageLim = (PAGES_PER_PROCESS < MaxPages) ? PAGES_PER_PROCESS : MaxPages;
  // Reciprocal of the page size, exact for 12-bit counters and sizes up to 64 KiB
  localparam int RecipS  = 28;
  localparam longint RecipL = ((64'd1 << RecipS) + longint'(PAGE_BYTES) - 64'd1)
                              / longint'(PAGE_BYTES);
  localparam logic [28:0] RecipM = 29'(RecipL);
  localparam int ProdW   = PcW + 29;

  // Sequencer and working registers
  lpvs_state_e        state_q, state_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [StampW-1:0]  tick_q, tick_d;

  logic [PidW-1:0]    pid_q;
  logic               act_q;
  logic [PcW-1:0]     pc_q;
  logic [ResW-1:0]    res_q;
  logic [CountW-1:0]  cnt_q;
  logic               full_q;
  logic               eor_q;

  logic [7:0]         page_q, page_d;
  logic [AddrW-1:0]   base_q, base_d;
  logic [CountW-1:0]  lim_q, lim_d;
  logic [CountW-1:0]  scan_q, scan_d;
  logic               rd_pend_q, rd_pend_d;
  logic [PageW-1:0]   rd_page_q, rd_page_d;

  logic [PageW-1:0]   want_q, want_d;
  logic               pagein_q, pagein_d;
  logic               found_q, found_d;
  logic [PageW-1:0]   victim_q, victim_d;
  logic [StampW-1:0]  least_q, least_d;

  // Output register
  logic               o_valid_q, o_valid_d;
  logic [PageW-1:0]   o_want_q;
  logic               o_pagein_q;
  logic               o_pageout_q;
  logic               o_found_q;
  logic [PageW-1:0]   o_victim_q;
  logic               o_load;

  // Stamp memory ports
  logic [StampW-1:0]  mem_q [Depth];
  logic               mem_we;
  logic [AddrW-1:0]   mem_wa;
  logic [StampW-1:0]  mem_wd;
  logic               mem_re;
  logic [AddrW-1:0]   mem_ra;
  logic [StampW-1:0]  mem_rdata_q;

  logic [ProdW-1:0]   prod;
  logic               item_ok;
  logic               page_ok;
  logic               cand;
  logic [CountW-1:0]  lim_c;

  assign in_i.ready = (state_q == S_IDLE);
  assign prod       = pc_q * RecipM;
  assign item_ok    = act_q && (9'(pid_q) < 9'(PROCESS_SLOTS));
  assign page_ok    = (page_q < 8'(PAGES_PER_PROCESS)) && (page_q < 8'(MaxPages));
  assign lim_c      = (cnt_q < CountW'(PageLim)) ? cnt_q : CountW'(PageLim);
  assign cand       = rd_pend_q && res_q[rd_page_q] && (rd_page_q != page_q[PageW-1:0]);

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      pid_q  <= in_i.process_id;
      act_q  <= in_i.is_active;
      pc_q   <= in_i.program_counter;
      res_q  <= in_i.resident_pages;
      cnt_q  <= in_i.page_count;
      full_q <= in_i.memory_full;
      eor_q  <= in_i.end_of_round;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      tick_q    <= StampW'(1);
      rd_pend_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      tick_q    <= tick_d;
      rd_pend_q <= rd_pend_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    base_q    <= base_d;
    lim_q     <= lim_d;
    scan_q    <= scan_d;
    rd_page_q <= rd_page_d;
    want_q    <= want_d;
    pagein_q  <= pagein_d;
    found_q   <= found_d;
    victim_q  <= victim_d;
    least_q   <= least_d;
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_want_q    <= want_q;
      o_pagein_q  <= pagein_q;
      o_pageout_q <= found_q;
      o_found_q   <= found_q;
      o_victim_q  <= victim_q;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    tick_d    = tick_q;
    page_d    = page_q;
    base_d    = base_q;
    lim_d     = lim_q;
    scan_d    = scan_q;
    rd_pend_d = 1'b0;
    rd_page_d = rd_page_q;
    want_d    = want_q;
    pagein_d  = pagein_q;
    found_d   = found_q;
    victim_d  = victim_q;
    least_d   = least_q;
    o_load    = 1'b0;
    o_valid_d = o_valid_q && !out_o.ready;
    mem_we    = 1'b0;
    mem_wa    = clr_q;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = base_q + AddrW'(scan_q[PageW-1:0]);

    unique case (state_q)
      // Zero the stamp memory one entry a cycle
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_DIV;
        end
      end
      // Divide the counter by the page size and form the row base
      S_DIV: begin
        page_d  = prod[RecipS+7:RecipS];
        base_d  = AddrW'(AddrW'(pid_q) * AddrW'(PAGES_PER_PROCESS));
        state_d = S_EVAL;
      end
      // Stamp the current page and decide on a search
      S_EVAL: begin
        want_d   = item_ok ? page_q[PageW-1:0] : '0;
        pagein_d = 1'b0;
        found_d  = 1'b0;
        victim_d = '0;
        least_d  = '0;
        scan_d   = '0;
        lim_d    = lim_c;
        state_d  = S_DONE;
        if (item_ok && page_ok) begin
          mem_we   = 1'b1;
          mem_wa   = base_q + AddrW'(page_q[PageW-1:0]);
          mem_wd   = tick_q;
          pagein_d = !res_q[page_q[PageW-1:0]];
          if (!res_q[page_q[PageW-1:0]] && full_q) begin
            state_d = S_SEARCH;
          end
        end
      end
      // Issue one stamp read a cycle and fold in the previous one
      S_SEARCH: begin
        if (scan_q < lim_q) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_page_d = scan_q[PageW-1:0];
          scan_d    = scan_q + CountW'(1);
        end else begin
          state_d = S_DONE;
        end
        if (cand && (!found_q || (mem_rdata_q < least_q))) begin
          found_d  = 1'b1;
          least_d  = mem_rdata_q;
          victim_d = rd_page_q;
        end
      end
      // Hand the result over once the output register is free and, at end of round, advance the tick unless saturated
      S_DONE: begin
        if (!o_valid_q || out_o.ready) begin
          o_load    = 1'b1;
          o_valid_d = 1'b1;
          state_d   = S_IDLE;
          if (eor_q && (tick_q != '1)) begin
            tick_d = tick_q + StampW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Stamp memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_ra];
    end
  end

  assign out_o.valid           = o_valid_q;
  assign out_o.want_page       = o_want_q;
  assign out_o.request_pagein  = o_pagein_q;
  assign out_o.request_pageout = o_pageout_q;
  assign out_o.victim_found    = o_found_q;
  assign out_o.victim_page     = o_victim_q;

  // Checks
  `LPVS_ASSERT_IMPL(a_no_write_in_search, clk_i, rst_ni, state_q == S_SEARCH, !mem_we)
  `LPVS_ASSERT_IMPL(a_victim_not_current, clk_i, rst_ni, (state_q == S_DONE) && found_q, victim_q != page_q[PageW-1:0])
  `LPVS_ASSERT_NEXT(a_tick_monotonic, clk_i, rst_ni, state_q != S_CLEAR, tick_q >= $past(tick_q))

endmodule
